[rtl/ilid_pkg.sv]
// Package with the shared types, codes and sizes of the indexed list unit.
package ilid_pkg;

	// Number of list entries; the four-bit index field addresses exactly this many.
	localparam int DEPTH = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OPC_W = 3;
	localparam int IDX_W = 4;
	localparam int ITEM_W = 32;
	localparam int CNT_W = 5;
	localparam int STS_W = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_INSERT = 3'd1,
		OP_POP    = 3'd2,
		OP_DELETE = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		OS_IDLE,
		OS_HOLD
	} out_state_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic exec;
	} ilid_cmd_t;

endpackage

[rtl/ilid_req_if.sv]
// Request channel interface: opcode, index and data word with valid and ready.
interface ilid_req_if import ilid_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OPC_W-1:0]  opcode;
	logic [IDX_W-1:0]  index;
	logic [ITEM_W-1:0] item;

	modport source (output valid, output opcode, output index, output item, input ready);
	modport sink (input valid, input opcode, input index, input item, output ready);
endinterface

[rtl/ilid_rsp_if.sv]
// Response channel interface: read word, count, empty flag and status.
interface ilid_rsp_if import ilid_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ITEM_W-1:0] read_data;
	logic [CNT_W-1:0]  count;
	logic              is_empty;
	logic [STS_W-1:0]  status;

	modport source (output valid, output read_data, output count, output is_empty,
		output status, input ready);
	modport sink (input valid, input read_data, input count, input is_empty,
		input status, output ready);
endinterface

[rtl/ilid_cfg_if.sv]
// Configuration write channel interface carrying the capacity limit.
interface ilid_cfg_if import ilid_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/ilid_ctrl.sv]
// Controller state machine: request acceptance and response register occupancy.
module ilid_ctrl import ilid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output ilid_cmd_t cmd
);

	out_state_t state_q;
	out_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// A new request may enter whenever the response register is free or is
	// being emptied in this cycle.
	always_comb begin
		state_nxt = state_q;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		cmd.exec  = 1'b0;
		case (state_q)
			OS_IDLE: begin
				req_ready = 1'b1;
				cmd.exec  = req_valid;
				if (req_valid) begin
					state_nxt = OS_HOLD;
				end
			end
			OS_HOLD: begin
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
				cmd.exec  = req_valid && rsp_ready;
				if (rsp_ready && !req_valid) begin
					state_nxt = OS_IDLE;
				end
			end
			default: begin
				state_nxt = OS_IDLE;
			end
		endcase
	end

endmodule

[rtl/ilid_dpath.sv]
// Datapath: entry registers with parallel shift, fill count, capacity and result register.
module ilid_dpath import ilid_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ilid_cmd_t         cmd,
	input  logic [OPC_W-1:0]  req_opcode,
	input  logic [IDX_W-1:0]  req_index,
	input  logic [ITEM_W-1:0] req_item,
	input  logic              cfg_valid,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic [ITEM_W-1:0] rsp_read_data,
	output logic [CNT_W-1:0]  rsp_count,
	output logic              rsp_is_empty,
	output logic [STS_W-1:0]  rsp_status
);

	logic [DATA_WIDTH-1:0] entries_q [DEPTH];
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      cap_q;

	logic [ITEM_W-1:0]     rd_data_q;
	logic [CNT_W-1:0]      count_q;
	logic                  empty_q;
	status_t               status_q;

	logic [DATA_WIDTH+ITEM_W-1:0] item_ext;
	logic [DATA_WIDTH+ITEM_W-1:0] rd_ext;
	logic [DATA_WIDTH-1:0]        wdata;
	logic [DATA_WIDTH-1:0]        rd_word;
	logic [CNT_W-1:0]             eff_cap;
	logic [CNT_W-1:0]             pos;
	logic [CNT_W-1:0]             fill_nxt;
	logic                         do_ins;
	logic                         do_del;
	status_t                      status_nxt;

	// The item is cut or zero-extended to the stored width; the read word likewise.
	assign item_ext = {{DATA_WIDTH{1'b0}}, req_item};
	assign wdata    = item_ext[DATA_WIDTH-1:0];
	assign rd_ext   = {{ITEM_W{1'b0}}, rd_word};
	assign eff_cap  = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;

	always_comb begin
		fill_nxt   = fill_q;
		status_nxt = ST_OK;
		rd_word    = '0;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		pos        = '0;
		case (req_opcode)
			OP_PUSH, OP_INSERT: begin
				if (fill_q >= eff_cap) begin
					status_nxt = ST_FULL;
				end else begin
					pos = (req_opcode == OP_PUSH) ? fill_q : {1'b0, req_index};
					if (pos > fill_q) begin
						status_nxt = ST_RANGE;
					end else begin
						do_ins   = 1'b1;
						fill_nxt = fill_q + CNT_W'(1);
					end
				end
			end
			OP_POP, OP_DELETE, OP_READ: begin
				if (fill_q == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					pos = (req_opcode == OP_POP) ? fill_q - CNT_W'(1) : {1'b0, req_index};
					if (pos >= fill_q) begin
						status_nxt = ST_RANGE;
					end else if (req_opcode == OP_READ) begin
						rd_word = entries_q[pos[IDX_W-1:0]];
					end else begin
						if (req_opcode == OP_POP) begin
							rd_word = entries_q[pos[IDX_W-1:0]];
						end
						do_del   = 1'b1;
						fill_nxt = fill_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Each entry takes its lower neighbor on insert and its upper neighbor on delete.
	for (genvar g = 0; g < DEPTH; g++) begin : g_entry
		logic [DATA_WIDTH-1:0] below;
		logic [DATA_WIDTH-1:0] above;
		if (g == 0) begin : g_first
			assign below = wdata;
		end else begin : g_rest
			assign below = entries_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign above = entries_q[g];
		end else begin : g_inner
			assign above = entries_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec && do_ins) begin
				if (CNT_W'(g) == pos) begin
					entries_q[g] <= wdata;
				end else if (CNT_W'(g) > pos) begin
					entries_q[g] <= below;
				end
			end else if (cmd.exec && do_del && CNT_W'(g) >= pos) begin
				entries_q[g] <= above;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cap_q  <= CAP_RESET;
		end else begin
			if (cmd.exec) begin
				fill_q <= fill_nxt;
			end
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_data_q <= rd_ext[ITEM_W-1:0];
			count_q   <= fill_nxt;
			empty_q   <= (fill_nxt == '0);
			status_q  <= status_nxt;
		end
	end

	assign rsp_read_data = rd_data_q;
	assign rsp_count     = count_q;
	assign rsp_is_empty  = empty_q;
	assign rsp_status    = status_q;

endmodule

[rtl/indexed_list_insert_delete_unit.sv]
// Top level of the indexed list unit: bounded ordered list with insert and delete.
// The unit keeps up to sixteen data words in order together with a fill count.
// Each request transaction pushes a word at the end, inserts a word at an index
// (later entries move up by one), pops the last word, deletes the word at an
// index (later entries move down by one), or reads the word at an index, and
// gives exactly one response transaction with the read or popped word (zero
// otherwise), the new count, an empty flag and a status: ok, full, empty, or
// index out of range. A rejected request changes nothing. Codes five to seven
// are ignored and answer ok. The capacity limit written on the configuration
// channel caps the count; values above sixteen act as sixteen and zero makes
// the list permanently full. Configuration is accepted in every cycle and
// should be written only while no request is in flight. All entry registers
// shift in parallel in the same edge that accepts a request, and the response
// lands in an output register. That register decouples the two channels, so a
// request is taken in the cycle the pending response is taken, giving one
// transaction per clock when the sink keeps up; the response is presented in
// the cycle after its request is accepted. There is no clearing pass after
// reset; entries above the count are never observed.
module indexed_list_insert_delete_unit import ilid_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ilid_req_if.sink   req,
	ilid_rsp_if.source rsp,
	ilid_cfg_if.sink   cfg
);

	ilid_cmd_t cmd;

	// The capacity register has no busy period.
	assign cfg.ready = 1'b1;

	// The controller decides when a request transaction executes and when a
	// response is presented.
	ilid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// The datapath holds the entries, the count and the response register.
	ilid_dpath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_opcode    (req.opcode),
		.req_index     (req.index),
		.req_item      (req.item),
		.cfg_valid     (cfg.valid),
		.cfg_data      (cfg.data),
		.rsp_read_data (rsp.read_data),
		.rsp_count     (rsp.count),
		.rsp_is_empty  (rsp.is_empty),
		.rsp_status    (rsp.status)
	);

	// The reported count can never exceed the number of entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.count <= CNT_W'(DEPTH)))
		else $error("response count exceeds list depth");

	// The empty flag must agree with the count it travels with.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.is_empty == (rsp.count == '0)))
		else $error("empty flag disagrees with count");

	// A rejected request never returns data.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_OK)) |-> (rsp.read_data == '0))
		else $error("rejected request returned data");

	// Every accepted request has a response waiting in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> rsp.valid)
		else $error("accepted request produced no response");

	// A pending response that is not taken blocks new requests.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("request accepted over an unread response");

endmodule

[test/tb_indexed_list_insert_delete_unit.sv]
// Self-checking testbench for the indexed list unit: directed table, then randomized phases.
`timescale 1ns / 1ps

module tb_indexed_list_insert_delete_unit;
	import ilid_pkg::*;

	// Codes five to seven are not operations; the unit answers them with ok and no change.
	localparam logic [OPC_W-1:0] OPC_SPARE_LO = 3'd5;
	localparam logic [OPC_W-1:0] OPC_SPARE_HI = 3'd7;

	// Random part: ten phases of list operations, one capacity setting each.
	localparam int PHASE_COUNT = 10;
	localparam int PHASE_ITEMS = 125;

	// Length of the long response back-pressure stretch, in clock cycles.
	localparam int RSP_HOLD_CYCLES = 60;

	// Cycles allowed for the unit to settle after the last response.
	localparam int SETTLE_CYCLES = 4;

	// Hard stop for the whole run. A correct run ends well before this limit, even
	// with the worst sender gaps and receiver stalls.
	localparam int RUN_LIMIT_NS = 4_000_000;

	// One response transaction as the unit should present it.
	typedef struct packed {
		logic [ITEM_W-1:0] read_data;
		logic [CNT_W-1:0]  count;
		logic              is_empty;
		status_t           status;
	} list_answer_t;

	// One row of the directed table. A row either writes the capacity limit or
	// sends one request; a request row may carry a typed-in answer.
	typedef struct {
		bit                set_cap;
		logic [CNT_W-1:0]  cap;
		logic [OPC_W-1:0]  opc;
		logic [IDX_W-1:0]  idx;
		logic [ITEM_W-1:0] word;
		bit                typed;
		list_answer_t      want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	ilid_req_if req_ch ();
	ilid_rsp_if rsp_ch ();
	ilid_cfg_if cfg_ch ();

	indexed_list_insert_delete_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the list contents, the fill count and the capacity limit.
	logic [ITEM_W-1:0] shadow_words [DEPTH];
	int                shadow_count;
	int                shadow_cap;

	// Answers owed by the unit, oldest first.
	list_answer_t pending_answer_q [$];

	stim_row_t directed_rows [$];

	// Driven alongside the request payload: whether the answer of the request
	// on the channel is typed in, and if so what it is.
	bit           drv_typed;
	list_answer_t drv_want;

	list_answer_t predicted;
	list_answer_t want;
	int           fail_count;

	// The stimulus bumps hold_requests to ask the receiver for one long stall.
	int hold_requests;
	int holds_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the shadow list and returns the answer it causes.
	// Full is checked before the index; a rejected request leaves the list alone.
	function automatic list_answer_t apply_list_op(input logic [OPC_W-1:0] opc,
		input logic [IDX_W-1:0] idx_in, input logic [ITEM_W-1:0] word);
		list_answer_t a;
		int           pos;
		int           cap_eff;
		int           i;
		a.read_data = '0;
		a.status = ST_OK;
		cap_eff = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
		pos = idx_in;
		case (opc)
			OP_PUSH, OP_INSERT: begin
				if (shadow_count >= cap_eff) begin
					a.status = ST_FULL;
				end else begin
					if (opc == OP_PUSH)
						pos = shadow_count;
					// An insert at the fill count appends; anything above is out of range.
					if (pos > shadow_count) begin
						a.status = ST_RANGE;
					end else begin
						for (i = shadow_count; i > pos; i--)
							shadow_words[i] = shadow_words[i - 1];
						shadow_words[pos] = word;
						shadow_count++;
					end
				end
			end
			OP_POP, OP_DELETE, OP_READ: begin
				if (shadow_count == 0) begin
					a.status = ST_EMPTY;
				end else begin
					if (opc == OP_POP)
						pos = shadow_count - 1;
					if (pos >= shadow_count) begin
						a.status = ST_RANGE;
					end else if (opc == OP_READ) begin
						a.read_data = shadow_words[pos];
					end else begin
						if (opc == OP_POP)
							a.read_data = shadow_words[pos];
						for (i = pos; i + 1 < shadow_count; i++)
							shadow_words[i] = shadow_words[i + 1];
						shadow_count--;
					end
				end
			end
			default: begin
			end
		endcase
		a.count = CNT_W'(shadow_count);
		a.is_empty = (shadow_count == 0);
		return a;
	endfunction

	// Everything is observed at the rising edge, before the unit's registers
	// move, so each handshake is seen exactly as the unit sees it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				shadow_cap = cfg_ch.data;
			if (req_ch.valid && req_ch.ready) begin
				// The shadow list is updated on every accepted request, even when the
				// answer of the row is typed in, so that later rows stay in step.
				predicted = apply_list_op(req_ch.opcode, req_ch.index, req_ch.item);
				pending_answer_q.push_back(drv_typed ? drv_want : predicted);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_answer_q.size() == 0) begin
					$error("response transaction with no request waiting for it");
					fail_count++;
				end else begin
					want = pending_answer_q.pop_front();
					if (rsp_ch.read_data !== want.read_data) begin
						$error("read_data: expected %h, actual %h", want.read_data,
							rsp_ch.read_data);
						fail_count++;
					end
					if (rsp_ch.count !== want.count) begin
						$error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
						fail_count++;
					end
					if (rsp_ch.is_empty !== want.is_empty) begin
						$error("is_empty: expected %b, actual %b", want.is_empty,
							rsp_ch.is_empty);
						fail_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
						fail_count++;
					end
				end
			end
		end
	end

	// Offers one request from the current falling edge until it is taken, and
	// returns at the falling edge after the transaction. Valid stays high, so a
	// request sent right away follows back to back.
	task automatic send_request(input logic [OPC_W-1:0] opc, input logic [IDX_W-1:0] idx,
		input logic [ITEM_W-1:0] word, input bit typed, input list_answer_t answer);
		req_ch.valid <= 1'b1;
		req_ch.opcode <= opc;
		req_ch.index <= idx;
		req_ch.item <= word;
		drv_typed <= typed;
		drv_want <= answer;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_request(input int cycles);
		if (cycles > 0) begin
			req_ch.valid <= 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Stops offering requests until every owed answer has arrived. It always ends
	// by waiting for a falling edge, so valid is never lowered and raised in
	// the same step.
	task automatic wait_for_answers();
		req_ch.valid <= 1'b0;
		while (pending_answer_q.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// The capacity limit is changed only while the unit is idle: no answer owed
	// and a wait of SETTLE_CYCLES for the last response to clear the output register.
	task automatic write_capacity(input logic [CNT_W-1:0] cap);
		req_ch.valid <= 1'b0;
		while (pending_answer_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= cap;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic dir_row(input logic [OPC_W-1:0] opc, input logic [IDX_W-1:0] idx,
		input logic [ITEM_W-1:0] word, input bit typed, input logic [CNT_W-1:0] cnt,
		input status_t st);
		stim_row_t r;
		r.set_cap = 1'b0;
		r.cap = '0;
		r.opc = opc;
		r.idx = idx;
		r.word = word;
		r.typed = typed;
		r.want.read_data = '0;
		r.want.count = cnt;
		r.want.is_empty = (cnt == 0);
		r.want.status = st;
		directed_rows.push_back(r);
	endtask

	task automatic dir_cap(input logic [CNT_W-1:0] cap);
		stim_row_t r;
		r.set_cap = 1'b1;
		r.cap = cap;
		r.opc = OP_PUSH;
		r.idx = '0;
		r.word = '0;
		r.typed = 1'b0;
		r.want = '0;
		directed_rows.push_back(r);
	endtask

	// Receiver: stalls on a rotating ready pattern that is reloaded after each full
	// rotation with a fresh density (never stalling, half, three quarters or a
	// quarter ready). On request it holds ready low for a long stretch, which
	// fills the output register and stalls the request channel behind it.
	initial begin
		logic [31:0] stall_pattern;
		int          hold_left;
		int          pattern_age;
		rsp_ch.ready = 1'b0;
		stall_pattern = '1;
		hold_left = 0;
		pattern_age = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_requests != holds_done) begin
				holds_done++;
				hold_left = RSP_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (pattern_age == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pattern = '1;
						1: stall_pattern = $urandom;
						2: stall_pattern = $urandom | $urandom;
						default: stall_pattern = $urandom & $urandom;
					endcase
					pattern_age = 32;
				end
				pattern_age--;
				rsp_ch.ready <= stall_pattern[0];
				stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
			end
		end
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("FAILED: results differ");
		$finish;
	end

	// Stimulus: reset, the directed table, then the random phases.
	initial begin
		int               phase_caps [5] = '{16, 1, 31, 0, 17};
		int               phase;
		int               sent;
		int               burst;
		int               mode;
		int               pick;
		bit               mid_done;
		logic [OPC_W-1:0] opc;
		logic [IDX_W-1:0] idx;
		logic [ITEM_W-1:0] word;
		logic [CNT_W-1:0] cap;
		stim_row_t        row;

		req_ch.valid = 1'b0;
		req_ch.opcode = OP_PUSH;
		req_ch.index = '0;
		req_ch.item = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		drv_typed = 1'b0;
		drv_want = '0;
		fail_count = 0;
		hold_requests = 0;
		holds_done = 0;
		foreach (shadow_words[i])
			shadow_words[i] = '0;
		shadow_count = 0;
		shadow_cap = CAP_RESET;

		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Right after reset the list is empty and the capacity is sixteen.
		dir_row(OP_POP, 4'd0, 32'h0, 1'b1, 5'd0, ST_EMPTY);
		dir_row(OP_READ, 4'd0, 32'h0, 1'b1, 5'd0, ST_EMPTY);
		dir_row(OP_DELETE, 4'd15, 32'h0, 1'b1, 5'd0, ST_EMPTY);
		// Insert past the fill count is out of range, even on an empty list.
		dir_row(OP_INSERT, 4'd1, 32'hDEAD_BEEF, 1'b1, 5'd0, ST_RANGE);
		dir_row(OP_PUSH, 4'd9, 32'hFFFF_FFFF, 1'b1, 5'd1, ST_OK);
		dir_row(OP_PUSH, 4'd0, 32'h0000_0000, 1'b1, 5'd2, ST_OK);
		dir_row(OP_INSERT, 4'd0, 32'hA5A5_A5A5, 1'b1, 5'd3, ST_OK);
		// Insert at exactly the fill count appends.
		dir_row(OP_INSERT, 4'd3, 32'h5A5A_5A5A, 1'b1, 5'd4, ST_OK);
		dir_row(OP_READ, 4'd0, 32'h0, 1'b0, 5'd0, ST_OK);
		// Read and delete at the fill count are out of range.
		dir_row(OP_READ, 4'd4, 32'h0, 1'b1, 5'd4, ST_RANGE);
		dir_row(OP_DELETE, 4'd4, 32'h0, 1'b1, 5'd4, ST_RANGE);
		dir_row(OP_INSERT, 4'd15, 32'h1234_5678, 1'b1, 5'd4, ST_RANGE);
		dir_row(OP_DELETE, 4'd1, 32'h0, 1'b0, 5'd0, ST_OK);
		dir_row(OP_READ, 4'd1, 32'h0, 1'b0, 5'd0, ST_OK);
		dir_row(OP_POP, 4'd15, 32'hFFFF_FFFF, 1'b0, 5'd0, ST_OK);
		// Unused codes change nothing.
		dir_row(OPC_SPARE_LO, 4'd15, 32'hFFFF_FFFF, 1'b0, 5'd0, ST_OK);
		dir_row(OPC_SPARE_HI, 4'd0, 32'h0, 1'b0, 5'd0, ST_OK);
		// With the capacity at the fill count the list is full, and full wins over
		// a bad index.
		dir_cap(5'd2);
		dir_row(OP_PUSH, 4'd0, 32'hCAFE_F00D, 1'b1, 5'd2, ST_FULL);
		dir_row(OP_INSERT, 4'd15, 32'hCAFE_F00D, 1'b1, 5'd2, ST_FULL);
		// A capacity of zero keeps the list full; removal and reads still work.
		dir_cap(5'd0);
		dir_row(OP_POP, 4'd0, 32'h0, 1'b0, 5'd0, ST_OK);
		dir_row(OP_INSERT, 4'd0, 32'h0BAD_0BAD, 1'b1, 5'd1, ST_FULL);
		dir_row(OP_READ, 4'd0, 32'h0, 1'b0, 5'd0, ST_OK);
		// Values above sixteen act as sixteen.
		dir_cap(5'd31);
		dir_row(OP_PUSH, 4'd0, 32'h1357_9BDF, 1'b0, 5'd0, ST_OK);
		dir_row(OP_DELETE, 4'd0, 32'h0, 1'b0, 5'd0, ST_OK);

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.set_cap) begin
				write_capacity(row.cap);
			end else begin
				send_request(row.opc, row.idx, row.word, row.typed, row.want);
				idle_request($urandom_range(0, 2));
			end
		end

		// Random phases. Bursts lean toward filling, draining or reading so the
		// list swings between empty and full at every capacity. Most indexes are
		// legal for the current fill count; the rest span the whole field.
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			cap = (phase < 5) ? CNT_W'(phase_caps[phase]) : CNT_W'($urandom_range(0, 31));
			write_capacity(cap);
			sent = 0;
			mid_done = 1'b0;
			while (sent < PHASE_ITEMS) begin
				mode = $urandom_range(0, 2);
				burst = $urandom_range(1, 24);
				// The last burst of a phase stops at the phase's item count.
				if (burst > PHASE_ITEMS - sent)
					burst = PHASE_ITEMS - sent;
				repeat (burst) begin
					pick = $urandom_range(0, 99);
					if (pick < 4) begin
						opc = OPC_SPARE_LO + OPC_W'($urandom_range(0, 2));
					end else if (mode == 0) begin
						opc = (pick < 70) ? OP_PUSH : (pick < 85) ? OP_INSERT :
							OPC_W'($urandom_range(OP_POP, OP_READ));
						if (pick >= 55 && pick < 70)
							opc = OP_INSERT;
					end else if (mode == 1) begin
						opc = (pick < 45) ? OP_POP : (pick < 75) ? OP_DELETE :
							(pick < 85) ? OP_READ : OPC_W'($urandom_range(OP_PUSH, OP_INSERT));
					end else begin
						opc = (pick < 60) ? OP_READ : OPC_W'($urandom_range(OP_PUSH, OP_DELETE));
					end

					if ($urandom_range(0, 9) < 8) begin
						if (opc == OP_INSERT)
							idx = IDX_W'($urandom_range(0, (shadow_count > 15) ? 15 : shadow_count));
						else
							idx = (shadow_count > 0) ? IDX_W'($urandom_range(0, shadow_count - 1))
								: '0;
					end else begin
						idx = IDX_W'($urandom_range(0, 15));
					end

					case ($urandom_range(0, 9))
						0: word = '0;
						1: word = '1;
						default: word = $urandom;
					endcase

					send_request(opc, idx, word, 1'b0, '0);
					if (opc <= OP_READ)
						sent++;

					// Halfway through some phases: a long response stall while requests
					// keep coming, or a pause until every answer is in.
					if (!mid_done && sent >= PHASE_ITEMS / 2) begin
						mid_done = 1'b1;
						if (phase % 3 == 1)
							hold_requests++;
						else if (phase % 3 == 2)
							wait_for_answers();
					end
				end
				idle_request(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
			end
		end

		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

[indexed_list_insert_delete_unit.f]
rtl/ilid_pkg.sv
rtl/ilid_req_if.sv
rtl/ilid_rsp_if.sv
rtl/ilid_cfg_if.sv
rtl/ilid_ctrl.sv
rtl/ilid_dpath.sv
rtl/indexed_list_insert_delete_unit.sv
test/tb_indexed_list_insert_delete_unit.sv
